// ===== src/spcq_pkg.sv =====
// ----------------------------------------------------------------------------
// spcq_pkg: shared constants for the shape point/cube query core
// Shape codes, operation codes, register indexes and multiplier tiling.
// ----------------------------------------------------------------------------
package spcq_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;

   // Operand tile of the pipelined multipliers.
   localparam int MUL_CHUNK = 34;

   localparam int KIND_WIDTH      = 3;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [KIND_WIDTH-1:0] KIND_SPHERE     = 3'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_CYLINDER   = 3'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_COLUMN     = 3'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_PARABOLOID = 3'd3;
   localparam logic [KIND_WIDTH-1:0] KIND_HYPERBOLOID = 3'd4;

   localparam logic OP_POINT = 1'b0;
   localparam logic OP_CUBE  = 1'b1;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SHAPE_KIND = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CENTER_X   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CENTER_Y   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CENTER_Z   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SHAPE_SIZE = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SLOPE      = 3'd5;

endpackage

// ===== src/spcq_req_if.sv =====
// ----------------------------------------------------------------------------
// spcq_req_if: query request channel
// Valid/ready channel that carries one point or cube query per beat.
// ----------------------------------------------------------------------------
interface spcq_req_if #(
   parameter int COORD_WIDTH = spcq_pkg::COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic                          operation;
   logic signed [COORD_WIDTH-1:0] query_x;
   logic signed [COORD_WIDTH-1:0] query_y;
   logic signed [COORD_WIDTH-1:0] query_z;
   logic        [COORD_WIDTH-2:0] cube_side;

   modport source (output valid, operation, query_x, query_y, query_z, cube_side,
                   input ready);
   modport sink   (input valid, operation, query_x, query_y, query_z, cube_side,
                   output ready);
endinterface

// ===== src/spcq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// spcq_rsp_if: query response channel
// Valid/ready channel that carries the inside flag and the tested point.
// ----------------------------------------------------------------------------
interface spcq_rsp_if #(
   parameter int COORD_WIDTH = spcq_pkg::COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic                          inside_res;
   logic signed [COORD_WIDTH-1:0] tested_x;
   logic signed [COORD_WIDTH-1:0] tested_y;
   logic signed [COORD_WIDTH-1:0] tested_z;

   modport source (output valid, inside_res, tested_x, tested_y, tested_z,
                   input ready);
   modport sink   (input valid, inside_res, tested_x, tested_y, tested_z,
                   output ready);
endinterface

// ===== src/spcq_mul.sv =====
// ----------------------------------------------------------------------------
// spcq_mul: pipelined unsigned multiplier
// Tiles the operands, registers the partial products, then registers the sum.
// ----------------------------------------------------------------------------
module spcq_mul #(
   parameter int A_WIDTH = spcq_pkg::MUL_CHUNK,
   parameter int B_WIDTH = spcq_pkg::MUL_CHUNK
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic [A_WIDTH-1:0]         a,
   input  logic [B_WIDTH-1:0]         b,
   output logic [A_WIDTH+B_WIDTH-1:0] p
);
   import spcq_pkg::*;

   localparam int NA  = (A_WIDTH + MUL_CHUNK - 1) / MUL_CHUNK;
   localparam int NB  = (B_WIDTH + MUL_CHUNK - 1) / MUL_CHUNK;
   localparam int PAW = NA * MUL_CHUNK;
   localparam int PBW = NB * MUL_CHUNK;
   localparam int PW  = A_WIDTH + B_WIDTH;
   localparam int SW  = PAW + PBW;

   logic [PAW-1:0]           a_pad;
   logic [PBW-1:0]           b_pad;
   logic [2*MUL_CHUNK-1:0]   pp_ff [NA][NB];
   logic [SW-1:0]            sum_in;
   logic [PW-1:0]            p_ff;

   assign a_pad = PAW'(a);
   assign b_pad = PBW'(b);

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            sum_in = sum_in + (SW'(pp_ff[i][j]) << (MUL_CHUNK * (i + j)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
               pp_ff[i][j] <= a_pad[i*MUL_CHUNK +: MUL_CHUNK]
                            * b_pad[j*MUL_CHUNK +: MUL_CHUNK];
            end
         end
         p_ff <= sum_in[PW-1:0];
      end
   end

   assign p = p_ff;
endmodule

// ===== src/spcq_clamp.sv =====
// ----------------------------------------------------------------------------
// spcq_clamp: cube reduction stage
// Reduces a cube query to its point closest to the shape, one stage deep.
// ----------------------------------------------------------------------------
module spcq_clamp #(
   parameter int COORD_WIDTH = spcq_pkg::COORD_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_vld,
   input  logic                               operation,
   input  logic signed [COORD_WIDTH-1:0]      query_x,
   input  logic signed [COORD_WIDTH-1:0]      query_y,
   input  logic signed [COORD_WIDTH-1:0]      query_z,
   input  logic        [COORD_WIDTH-2:0]      cube_side,
   input  logic [spcq_pkg::KIND_WIDTH-1:0]    kind,
   input  logic signed [COORD_WIDTH-1:0]      center_x,
   input  logic signed [COORD_WIDTH-1:0]      center_y,
   input  logic signed [COORD_WIDTH-1:0]      center_z,
   input  logic signed [COORD_WIDTH-1:0]      shape_size,
   input  logic signed [COORD_WIDTH-1:0]      slope,
   output logic                               out_vld,
   output logic signed [COORD_WIDTH-1:0]      pt_x,
   output logic signed [COORD_WIDTH-1:0]      pt_y,
   output logic signed [COORD_WIDTH-1:0]      pt_z
);
   import spcq_pkg::*;

   localparam int W = COORD_WIDTH;

   logic [W-2:0]          half;
   logic                  is_cube;
   logic signed [W-1:0]   x_in, y_in, z_in;
   logic signed [W-1:0]   x_ff, y_ff, z_ff;
   logic                  vld_ff;

   function automatic logic signed [W-1:0] clamp_axis(
      input logic signed [W-1:0] c,
      input logic signed [W-1:0] q,
      input logic        [W-2:0] h
   );
      logic signed [W:0] d;
      logic        [W:0] m;
      logic signed [W:0] s;
      d = {c[W-1], c} - {q[W-1], q};
      m = d[W] ? -d : d;
      s = d[W] ? ({q[W-1], q} - {2'b00, h}) : ({q[W-1], q} + {2'b00, h});
      if (m < {2'b00, h}) begin
         return c;
      end
      return s[W-1:0];
   endfunction

   // Moves z by half a side and saturates to the coordinate range.
   function automatic logic signed [W-1:0] shift_sat(
      input logic signed [W-1:0] q,
      input logic        [W-2:0] h,
      input logic                down
   );
      logic signed [W:0] s;
      s = down ? ({q[W-1], q} - {2'b00, h}) : ({q[W-1], q} + {2'b00, h});
      if (s[W] != s[W-1]) begin
         return s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end
      return s[W-1:0];
   endfunction

   assign half    = {1'b0, cube_side[W-2:1]};
   assign is_cube = (operation == OP_CUBE) && (kind <= KIND_HYPERBOLOID);

   always_comb begin
      x_in = query_x;
      y_in = query_y;
      z_in = query_z;
      if (is_cube) begin
         x_in = clamp_axis(center_x, query_x, half);
         y_in = clamp_axis(center_y, query_y, half);
         unique case (kind)
            KIND_SPHERE: begin
               z_in = clamp_axis(center_z, query_z, half);
            end
            KIND_PARABOLOID: begin
               if (shape_size != '0) begin
                  z_in = shift_sat(query_z, half, !shape_size[W-1]);
               end
            end
            KIND_HYPERBOLOID: begin
               if (slope != '0) begin
                  z_in = shift_sat(query_z, half, !slope[W-1]);
               end
            end
            default: begin
               z_in = query_z;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_vld;
      end
   end

   assign out_vld = vld_ff;
   assign pt_x    = x_ff;
   assign pt_y    = y_ff;
   assign pt_z    = z_ff;
endmodule

// ===== src/spcq_eval.sv =====
// ----------------------------------------------------------------------------
// spcq_eval: containment test pipeline
// Differences, exact squares and wide products over eleven stages.
// ----------------------------------------------------------------------------
module spcq_eval #(
   parameter int COORD_WIDTH = spcq_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = spcq_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_vld,
   input  logic signed [COORD_WIDTH-1:0]      pt_x,
   input  logic signed [COORD_WIDTH-1:0]      pt_y,
   input  logic signed [COORD_WIDTH-1:0]      pt_z,
   input  logic [spcq_pkg::KIND_WIDTH-1:0]    kind,
   input  logic signed [COORD_WIDTH-1:0]      center_x,
   input  logic signed [COORD_WIDTH-1:0]      center_y,
   input  logic signed [COORD_WIDTH-1:0]      center_z,
   input  logic signed [COORD_WIDTH-1:0]      shape_size,
   input  logic signed [COORD_WIDTH-1:0]      slope,
   output logic                               out_vld,
   output logic                               out_inside,
   output logic signed [COORD_WIDTH-1:0]      out_x,
   output logic signed [COORD_WIDTH-1:0]      out_y,
   output logic signed [COORD_WIDTH-1:0]      out_z
);
   import spcq_pkg::*;

   localparam int W    = COORD_WIDTH;
   localparam int DW   = W + 1;
   localparam int SQW  = 2 * DW;
   localparam int XYW  = SQW + 1;
   localparam int SPW  = SQW + 2;
   localparam int S2W  = 2 * W;
   localparam int PARW = DW + W;
   localparam int PMW  = W + S2W;
   localparam int RHW  = XYW + S2W;
   localparam int HW   = ((PMW > DW + 2 * FRAC_BITS) ? PMW : DW + 2 * FRAC_BITS) + 3;
   localparam int LW   = DW + HW;
   localparam int CW   = (LW > RHW) ? LW : RHW;
   localparam int NST  = 11;
   localparam int LAST = NST - 1;

   logic                size_neg, slope_pos;
   logic [W-1:0]        size_abs, slope_abs;

   logic signed [DW-1:0] dx_c, dy_c, dz_c;

   logic                vld_ff [NST];
   logic [3*W-1:0]      pt_ff  [NST];
   logic [DW-1:0]       ax_ff, ay_ff;
   logic [DW-1:0]       az_ff  [8];
   logic signed [DW-1:0] dz_ff [6];
   logic                dzn_ff [10];
   logic                col_ff [10];
   logic                pbad_ff [4];
   logic [2:0]          fl_ff  [10];

   logic [SQW-1:0]      sqx_w, sqy_w, sqz_w;
   logic [2*W-1:0]      sqs_w;
   logic [S2W-1:0]      s2_w;
   logic [PARW-1:0]     par_w;
   logic [PMW-1:0]      pm_w;
   logic [RHW-1:0]      rh_w;
   logic [LW-1:0]       lm_w;

   logic [XYW-1:0]      xy2_ff;
   logic [SPW-1:0]      sph_ff;
   logic [2*W-1:0]      sqs_ff;
   logic [S2W-1:0]      s2_ff;
   logic [PARW-1:0]     par_ff;

   logic signed [HW-1:0] a_c, pm_c, zd_c, t_c;
   logic signed [HW-1:0] zd_ff, t_ff;
   logic [HW-1:0]       tabs_ff;
   logic                tneg_ff [10];
   logic                zdok_ff [10];
   logic [RHW-1:0]      rhs_ff  [10];

   logic                lneg_c, hyp_c, inside_in, inside_ff;

   function automatic logic [DW-1:0] absd(input logic signed [DW-1:0] v);
      return v[DW-1] ? -v : v;
   endfunction

   assign size_neg  = shape_size[W-1];
   assign size_abs  = size_neg ? -shape_size : shape_size;
   assign slope_abs = slope[W-1] ? -slope : slope;
   assign slope_pos = !slope[W-1] && (slope != '0);

   // Stage 0: offsets from the shape center.
   assign dx_c = {center_x[W-1], center_x} - {pt_x[W-1], pt_x};
   assign dy_c = {center_y[W-1], center_y} - {pt_y[W-1], pt_y};
   assign dz_c = {center_z[W-1], center_z} - {pt_z[W-1], pt_z};

   // Stages 1-2: squares and the paraboloid product.
   spcq_mul #(.A_WIDTH(DW), .B_WIDTH(DW)) u_sqx (
      .clock(clock), .en(en), .a(ax_ff), .b(ax_ff), .p(sqx_w));
   spcq_mul #(.A_WIDTH(DW), .B_WIDTH(DW)) u_sqy (
      .clock(clock), .en(en), .a(ay_ff), .b(ay_ff), .p(sqy_w));
   spcq_mul #(.A_WIDTH(DW), .B_WIDTH(DW)) u_sqz (
      .clock(clock), .en(en), .a(az_ff[0]), .b(az_ff[0]), .p(sqz_w));
   spcq_mul #(.A_WIDTH(W), .B_WIDTH(W)) u_sqs (
      .clock(clock), .en(en), .a(size_abs), .b(size_abs), .p(sqs_w));
   spcq_mul #(.A_WIDTH(W), .B_WIDTH(W)) u_s2 (
      .clock(clock), .en(en), .a(slope_abs), .b(slope_abs), .p(s2_w));
   spcq_mul #(.A_WIDTH(DW), .B_WIDTH(W)) u_par (
      .clock(clock), .en(en), .a(az_ff[0]), .b(size_abs), .p(par_w));

   // Stages 4-5: hyperboloid offset and the radial side of its test.
   spcq_mul #(.A_WIDTH(W), .B_WIDTH(S2W)) u_pm (
      .clock(clock), .en(en), .a(size_abs), .b(s2_ff), .p(pm_w));
   spcq_mul #(.A_WIDTH(XYW), .B_WIDTH(S2W)) u_rh (
      .clock(clock), .en(en), .a(xy2_ff), .b(s2_ff), .p(rh_w));

   // Stage 6: zd = dz*2^2F + p and t = dz*2^2F + 2p. The hyperboloid test
   // zd^2 - p^2 >= xy2*s2*2^2F reduces to dz*t >= xy2*s2.
   always_comb begin
      a_c  = HW'(dz_ff[5]) <<< (2 * FRAC_BITS);
      pm_c = $signed(HW'(pm_w));
      zd_c = size_neg ? (a_c - pm_c) : (a_c + pm_c);
      t_c  = size_neg ? (a_c - (pm_c <<< 1)) : (a_c + (pm_c <<< 1));
   end

   // Stages 8-9: left side of the hyperboloid test.
   spcq_mul #(.A_WIDTH(DW), .B_WIDTH(HW)) u_lm (
      .clock(clock), .en(en), .a(az_ff[7]), .b(tabs_ff), .p(lm_w));

   // Stage 10: final decision per shape.
   always_comb begin
      lneg_c = dzn_ff[9] ^ tneg_ff[9];
      hyp_c  = zdok_ff[9] && !(lneg_c && (lm_w != '0))
               && (CW'(lm_w) >= CW'(rhs_ff[9]));
      unique case (kind)
         KIND_SPHERE:      inside_in = fl_ff[9][2];
         KIND_CYLINDER:    inside_in = fl_ff[9][1];
         KIND_COLUMN:      inside_in = col_ff[9];
         KIND_PARABOLOID:  inside_in = fl_ff[9][0];
         KIND_HYPERBOLOID: inside_in = hyp_c;
         default:          inside_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pt_ff[0] <= {pt_x, pt_y, pt_z};
         for (int k = 1; k < NST; k++) begin
            pt_ff[k] <= pt_ff[k-1];
         end

         // stage 0
         ax_ff    <= absd(dx_c);
         ay_ff    <= absd(dy_c);
         az_ff[0] <= absd(dz_c);
         dz_ff[0] <= dz_c;
         dzn_ff[0] <= dz_c[DW-1];
         for (int k = 1; k < 8; k++) begin
            az_ff[k] <= az_ff[k-1];
         end
         for (int k = 1; k < 6; k++) begin
            dz_ff[k] <= dz_ff[k-1];
         end
         for (int k = 1; k < 10; k++) begin
            dzn_ff[k] <= dzn_ff[k-1];
         end

         // stage 1: column test and paraboloid side check
         col_ff[1] <= !size_neg
                      && ({ax_ff, 1'b0} <= (DW+1)'(size_abs))
                      && ({ay_ff, 1'b0} <= (DW+1)'(size_abs));
         pbad_ff[1] <= (dz_ff[0] != '0) && (shape_size != '0)
                       && (dz_ff[0][DW-1] != size_neg);
         for (int k = 2; k < 10; k++) begin
            col_ff[k] <= col_ff[k-1];
         end
         for (int k = 2; k < 4; k++) begin
            pbad_ff[k] <= pbad_ff[k-1];
         end

         // stage 3: sums of squares
         xy2_ff <= XYW'(sqx_w) + XYW'(sqy_w);
         sph_ff <= SPW'(sqx_w) + SPW'(sqy_w) + SPW'(sqz_w);
         sqs_ff <= sqs_w;
         s2_ff  <= s2_w;
         par_ff <= par_w;

         // stage 4: sphere, cylinder and paraboloid compares
         fl_ff[4] <= {!size_neg && (sph_ff <= SPW'(sqs_ff)),
                      !size_neg && (xy2_ff <= XYW'(sqs_ff)),
                      !pbad_ff[3] && (XYW'({par_ff, 1'b0}) >= xy2_ff)};
         for (int k = 5; k < 10; k++) begin
            fl_ff[k] <= fl_ff[k-1];
         end

         // stage 6
         zd_ff     <= zd_c;
         t_ff      <= t_c;
         rhs_ff[6] <= rh_w;

         // stage 7
         tabs_ff    <= t_ff[HW-1] ? -t_ff : t_ff;
         tneg_ff[7] <= t_ff[HW-1];
         zdok_ff[7] <= (zd_ff != '0) && (slope_pos ? !zd_ff[HW-1] : zd_ff[HW-1]);
         for (int k = 7; k < 10; k++) begin
            rhs_ff[k] <= rhs_ff[k-1];
         end
         for (int k = 8; k < 10; k++) begin
            tneg_ff[k] <= tneg_ff[k-1];
            zdok_ff[k] <= zdok_ff[k-1];
         end

         // stage 10: output register
         inside_ff <= inside_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NST; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= in_vld;
         for (int k = 1; k < NST; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   assign out_vld    = vld_ff[LAST];
   assign out_inside = inside_ff;
   assign out_x      = pt_ff[LAST][3*W-1:2*W];
   assign out_y      = pt_ff[LAST][2*W-1:W];
   assign out_z      = pt_ff[LAST][W-1:0];
endmodule

// ===== src/shape_point_cube_query_core.sv =====
// ----------------------------------------------------------------------------
// shape_point_cube_query_core: point and cube containment filter
// Tests points, or the nearest point of axis-aligned cubes, against one
// configured sphere, cylinder, column, paraboloid or hyperboloid.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Beat contents
//   req_chan  in         operation, query_x/y/z, cube_side
//   rsp_chan  out        inside_res, tested_x/y/z
//   csr_*     in         register write: csr_index selects, csr_wdata is data
//
// One query beat is accepted per cycle while the pipeline advances; each produces
// exactly one response beat, through 1 clamp stage and 11 test stages. The depth is set
// by the chain of three pipelined wide multiplications of the hyperboloid test.
// Reset is synchronous: it empties the pipeline and restores the registers.
// When a response waits and rsp_chan.ready is low, the whole pipeline holds.
// ----------------------------------------------------------------------------
module shape_point_cube_query_core #(
   parameter int COORD_WIDTH = spcq_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = spcq_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   spcq_req_if.sink                             req_chan,
   spcq_rsp_if.source                           rsp_chan,
   input  logic                                 csr_we,
   input  logic [spcq_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COORD_WIDTH-1:0]               csr_wdata
);
   import spcq_pkg::*;

   // Shape registers.
   logic [KIND_WIDTH-1:0]          kind_ff;
   logic signed [COORD_WIDTH-1:0]  center_x_ff;
   logic signed [COORD_WIDTH-1:0]  center_y_ff;
   logic signed [COORD_WIDTH-1:0]  center_z_ff;
   logic signed [COORD_WIDTH-1:0]  size_ff;
   logic signed [COORD_WIDTH-1:0]  slope_ff;

   // Pipeline advance: every stage moves when the output register is empty
   // or its beat is being taken in this cycle.
   logic                           advance;
   logic                           clamp_vld;
   logic signed [COORD_WIDTH-1:0]  clamp_x, clamp_y, clamp_z;
   logic                           res_vld;

   assign advance        = !res_vld || rsp_chan.ready;
   assign req_chan.ready = advance;

   // The user must change the shape registers only while no query is in flight;
   // the block does not enforce it, and every stage reads them directly.
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff     <= KIND_SPHERE;
         center_x_ff <= '0;
         center_y_ff <= '0;
         center_z_ff <= '0;
         size_ff     <= '0;
         slope_ff    <= COORD_WIDTH'(1) << FRAC_BITS;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_SHAPE_KIND: kind_ff     <= csr_wdata[KIND_WIDTH-1:0];
            REG_CENTER_X:   center_x_ff <= csr_wdata;
            REG_CENTER_Y:   center_y_ff <= csr_wdata;
            REG_CENTER_Z:   center_z_ff <= csr_wdata;
            REG_SHAPE_SIZE: size_ff     <= csr_wdata;
            REG_SLOPE:      slope_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // First stage: a cube collapses to the point of it that lies nearest the
   // shape (or on the z face that faces the opening of the quadric).
   spcq_clamp #(.COORD_WIDTH(COORD_WIDTH)) u_clamp (
      .clock      (clock),
      .reset      (reset),
      .en         (advance),
      .in_vld     (req_chan.valid),
      .operation  (req_chan.operation),
      .query_x    (req_chan.query_x),
      .query_y    (req_chan.query_y),
      .query_z    (req_chan.query_z),
      .cube_side  (req_chan.cube_side),
      .kind       (kind_ff),
      .center_x   (center_x_ff),
      .center_y   (center_y_ff),
      .center_z   (center_z_ff),
      .shape_size (size_ff),
      .slope      (slope_ff),
      .out_vld    (clamp_vld),
      .pt_x       (clamp_x),
      .pt_y       (clamp_y),
      .pt_z       (clamp_z)
   );

   // Remaining stages: exact squared compares; the last stage is the output
   // register that drives the response channel.
   spcq_eval #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_eval (
      .clock      (clock),
      .reset      (reset),
      .en         (advance),
      .in_vld     (clamp_vld),
      .pt_x       (clamp_x),
      .pt_y       (clamp_y),
      .pt_z       (clamp_z),
      .kind       (kind_ff),
      .center_x   (center_x_ff),
      .center_y   (center_y_ff),
      .center_z   (center_z_ff),
      .shape_size (size_ff),
      .slope      (slope_ff),
      .out_vld    (res_vld),
      .out_inside (rsp_chan.inside_res),
      .out_x      (rsp_chan.tested_x),
      .out_y      (rsp_chan.tested_y),
      .out_z      (rsp_chan.tested_z)
   );

   assign rsp_chan.valid = res_vld;
endmodule

// ===== src/spcq_check.sv =====
// ----------------------------------------------------------------------------
// spcq_check: port-level checks for the query core
// Watches the channels of the top level and is bound to it.
// ----------------------------------------------------------------------------
module spcq_check #(
   parameter int COORD_WIDTH = spcq_pkg::COORD_WIDTH_DEF
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_inside,
   input logic [COORD_WIDTH-1:0] rsp_x,
   input logic [COORD_WIDTH-1:0] rsp_y,
   input logic [COORD_WIDTH-1:0] rsp_z
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_inside) && $stable(rsp_x)
                                  && $stable(rsp_y) && $stable(rsp_z))
      else $error("response beat changed while stalled");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("query taken while the pipeline is frozen");

   a_empty_flows: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("query refused with an empty output register");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");
endmodule

bind shape_point_cube_query_core spcq_check #(.COORD_WIDTH(COORD_WIDTH)) u_spcq_check (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_inside (rsp_chan.inside_res),
   .rsp_x      (rsp_chan.tested_x),
   .rsp_y      (rsp_chan.tested_y),
   .rsp_z      (rsp_chan.tested_z)
);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for shape_point_cube_query_core
// Drives point and cube queries against every shape setting, predicts the
// inside flag and the tested point with wide exact arithmetic, and checks
// each response beat in order while both channel ends idle at random.
// ----------------------------------------------------------------------------
module tb;
   import spcq_pkg::*;

   typedef logic [255:0] wide_type;

   typedef struct {
      logic        inside_res;
      logic [31:0] tested_x;
      logic [31:0] tested_y;
      logic [31:0] tested_z;
   } query_result_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [31:0] csr_wdata;

   spcq_req_if req_chan ();
   spcq_rsp_if rsp_chan ();

   shape_point_cube_query_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan.sink),
      .rsp_chan  (rsp_chan.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the shape registers, kept at their reset values at start.
   logic [2:0] shape_kind_q = KIND_SPHERE;
   longint     center_x_q   = 0;
   longint     center_y_q   = 0;
   longint     center_z_q   = 0;
   longint     size_q       = 0;
   longint     slope_q      = 65536;

   query_result_type expected_results[$];
   bit            failed = 0;
   int            send_idle_pct = 0;
   int            recv_idle_pct = 0;
   int            recv_hold_cycles = 0;

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------
   function automatic logic [63:0] magnitude(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic wide_type square(logic [63:0] m);
      return wide_type'(m) * wide_type'(m);
   endfunction

   function automatic longint saturate32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Moves a cube's centre coordinate toward the shape by half a side, or
   // takes the shape's own coordinate once that lies within the cube.
   function automatic longint clamp_toward(longint c, longint q, longint half);
      if (magnitude(c - q) < 64'(half)) return c;
      return c > q ? q + half : q - half;
   endfunction

   function automatic logic shape_hit(longint px, longint py, longint pz);
      logic [63:0] ax, ay;
      longint      dz;
      wide_type    xy2, s2, pm, am, zm, rhs;
      logic        pneg, aneg, zneg;
      ax  = magnitude(center_x_q - px);
      ay  = magnitude(center_y_q - py);
      dz  = center_z_q - pz;
      xy2 = square(ax) + square(ay);
      case (shape_kind_q)
         KIND_SPHERE: begin
            if (size_q < 0) return 1'b0;
            return xy2 + square(magnitude(dz)) <= square(magnitude(size_q));
         end
         KIND_CYLINDER: begin
            if (size_q < 0) return 1'b0;
            return xy2 <= square(magnitude(size_q));
         end
         KIND_COLUMN: begin
            if (size_q < 0) return 1'b0;
            return (2 * ax <= 64'(size_q)) && (2 * ay <= 64'(size_q));
         end
         KIND_PARABOLOID: begin
            // The point must lie on the opening side of the vertex.
            if (dz != 0 && size_q != 0 && ((dz < 0) != (size_q < 0))) return 1'b0;
            return wide_type'(2 * magnitude(dz)) * wide_type'(magnitude(size_q)) >= xy2;
         end
         KIND_HYPERBOLOID: begin
            // Everything is scaled by 2^(2*FRAC) so the offset size*slope^2
            // stays exact; signs are carried beside the magnitudes.
            s2   = square(magnitude(slope_q));
            pm   = wide_type'(magnitude(size_q)) * s2;
            pneg = size_q < 0;
            am   = wide_type'(magnitude(dz)) << 32;
            aneg = dz < 0;
            if (pm == 0 || am == 0 || aneg == pneg) begin
               zm   = am + pm;
               zneg = (am == 0) ? pneg : aneg;
            end else if (am >= pm) begin
               zm   = am - pm;
               zneg = aneg;
            end else begin
               zm   = pm - am;
               zneg = pneg;
            end
            if (zm == 0) return 1'b0;
            // A zero slope falls on the same branch as a negative slope.
            if (slope_q > 0 ? zneg : !zneg) return 1'b0;
            rhs = pm * pm + ((xy2 * s2) << 32);
            return zm * zm >= rhs;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic query_result_type predict_query(logic op, longint x, longint y,
                                                      longint z, logic [30:0] side);
      query_result_type r;
      longint           half;
      if (op == OP_CUBE && shape_kind_q <= KIND_HYPERBOLOID) begin
         half = longint'(side >> 1);
         x = clamp_toward(center_x_q, x, half);
         y = clamp_toward(center_y_q, y, half);
         if (shape_kind_q == KIND_SPHERE) begin
            z = clamp_toward(center_z_q, z, half);
         end else if (shape_kind_q == KIND_PARABOLOID) begin
            if (size_q > 0) z = saturate32(z - half);
            else if (size_q < 0) z = saturate32(z + half);
         end else if (shape_kind_q == KIND_HYPERBOLOID) begin
            if (slope_q > 0) z = saturate32(z - half);
            else if (slope_q < 0) z = saturate32(z + half);
         end
      end
      r.inside_res = shape_hit(x, y, z);
      r.tested_x   = x[31:0];
      r.tested_y   = y[31:0];
      r.tested_z   = z[31:0];
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Channel drivers and response checker
   // ------------------------------------------------------------------------
   task automatic write_reg(logic [CSR_INDEX_WIDTH-1:0] index, logic [31:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = data;
      case (index)
         REG_SHAPE_KIND: shape_kind_q = data[2:0];
         REG_CENTER_X:   center_x_q   = longint'($signed(data));
         REG_CENTER_Y:   center_y_q   = longint'($signed(data));
         REG_CENTER_Z:   center_z_q   = longint'($signed(data));
         REG_SHAPE_SIZE: size_q       = longint'($signed(data));
         REG_SLOPE:      slope_q      = longint'($signed(data));
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Waits until every response is in, then lets the pipeline drain fully.
   task automatic wait_idle();
      while (expected_results.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic set_shape(logic [2:0] kind, logic [31:0] cx, logic [31:0] cy,
                            logic [31:0] cz, logic [31:0] size, logic [31:0] slope);
      wait_idle();
      write_reg(REG_SHAPE_KIND, 32'(kind));
      write_reg(REG_CENTER_X, cx);
      write_reg(REG_CENTER_Y, cy);
      write_reg(REG_CENTER_Z, cz);
      write_reg(REG_SHAPE_SIZE, size);
      write_reg(REG_SLOPE, slope);
   endtask

   // Offers one query beat and records its prediction once it is taken.
   // Valid stays high afterwards; the next call or finish_stimulus decides.
   task automatic send_query(logic op, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z, logic [30:0] side);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid     = 1'b1;
      req_chan.operation = op;
      req_chan.query_x   = x;
      req_chan.query_y   = y;
      req_chan.query_z   = z;
      req_chan.cube_side = side;
      do @(posedge clock); while (!req_chan.ready);
      expected_results.push_back(predict_query(op, longint'($signed(x)),
                                 longint'($signed(y)), longint'($signed(z)), side));
   endtask

   task automatic finish_stimulus();
      @(negedge clock);
      req_chan.valid = 1'b0;
   endtask

   // The receiver stalls at random, or for a whole counted hold-off.
   always @(negedge clock) begin
      if (recv_hold_cycles > 0) begin
         recv_hold_cycles--;
         rsp_chan.ready = 1'b0;
      end else begin
         rsp_chan.ready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      query_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: response beat with nothing expected", $time);
            failed = 1;
         end else begin
            want = expected_results.pop_front();
            if (rsp_chan.inside_res !== want.inside_res) begin
               $display("%0t: inside_res expected %0b actual %0b", $time,
                        want.inside_res, rsp_chan.inside_res);
               failed = 1;
            end
            if (rsp_chan.tested_x !== want.tested_x) begin
               $display("%0t: tested_x expected %h actual %h", $time,
                        want.tested_x, rsp_chan.tested_x);
               failed = 1;
            end
            if (rsp_chan.tested_y !== want.tested_y) begin
               $display("%0t: tested_y expected %h actual %h", $time,
                        want.tested_y, rsp_chan.tested_y);
               failed = 1;
            end
            if (rsp_chan.tested_z !== want.tested_z) begin
               $display("%0t: tested_z expected %h actual %h", $time,
                        want.tested_z, rsp_chan.tested_z);
               failed = 1;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Random values: full range, extremes, and signed values of random scale.
   // ------------------------------------------------------------------------
   function automatic logic [31:0] random_value();
      case ($urandom_range(4))
         0: return $urandom;
         1: begin
            case ($urandom_range(3))
               0: return 32'h7fff_ffff;
               1: return 32'h8000_0000;
               2: return 32'h0001_0000;
               default: return 32'h0;
            endcase
         end
         default: return $signed($urandom) >>> $urandom_range(31);
      endcase
   endfunction

   function automatic logic [30:0] random_side();
      if ($urandom_range(9) == 0) return 31'h7fff_ffff;
      return 31'($urandom >> $urandom_range(1, 31));
   endfunction

   // Near the shape most of the time, so that hits and misses both occur.
   function automatic logic [31:0] random_coord(longint c);
      if ($urandom_range(2) == 0) return random_value();
      return 32'(c) + ($signed($urandom) >>> $urandom_range(8, 31));
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Reset values: a sphere of radius zero at the origin, so only the
   // origin itself, or a cube around it, is inside.
   task automatic test_reset_shape();
      send_query(OP_POINT, 32'h0, 32'h0, 32'h0, 31'h0);
      send_query(OP_CUBE, 32'h0001_0000, 32'hffff_0000, 32'h0, 31'h0004_0000);
      finish_stimulus();
   endtask

   // Each shape, a negative size, a zero slope and unknown kinds, with
   // points at the centre and at the field extremes, and the largest cube.
   task automatic test_directed_shapes();
      logic [2:0]  kind;
      logic [31:0] size, slope;
      for (int k = 0; k < 8; k++) begin
         kind  = 3'(k);
         size  = (k == 2) ? 32'hfffe_0000 : 32'h0004_0000;
         slope = (k == 4) ? 32'hffff_0000 : 32'h0;
         if (k == 7) begin
            kind  = KIND_HYPERBOLOID;
            slope = 32'h0;
         end
         set_shape(kind, 32'h0001_0000, 32'hffff_8000, 32'h0002_0000, size, slope);
         send_query(OP_POINT, 32'h0001_0000, 32'hffff_8000, 32'h0002_0000, 31'h0);
         send_query(OP_POINT, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 31'h7fff_ffff);
         send_query(OP_CUBE, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff);
         finish_stimulus();
      end
   endtask

   task automatic random_shape();
      int          pick;
      logic [2:0]  kind;
      logic [31:0] size;
      pick = $urandom_range(11);
      kind = (pick < 10) ? 3'(pick % 5) : 3'(5 + pick % 3);
      // Mostly moderate positive sizes, so insides are common.
      size = ($urandom_range(3) == 0) ? random_value()
                                      : 32'($urandom_range(32'h0040_0000));
      set_shape(kind, random_value(), random_value(), random_value(), size,
                ($urandom_range(2) == 0) ? random_value()
                                         : 32'($signed($urandom) >>> $urandom_range(12, 20)));
   endtask

   task automatic test_random_queries(int shapes, int per_shape);
      for (int s = 0; s < shapes; s++) begin
         random_shape();
         for (int i = 0; i < per_shape; i++) begin
            send_query(1'($urandom), random_coord(center_x_q), random_coord(center_y_q),
                       random_coord(center_z_q), random_side());
         end
         finish_stimulus();
      end
   endtask

   // The receiver holds off long enough for the pipeline to fill and push
   // back on the sender, which keeps offering beats the whole time.
   task automatic test_backpressure();
      random_shape();
      send_idle_pct    = 0;
      recv_idle_pct    = 0;
      recv_hold_cycles = 200;
      for (int i = 0; i < 40; i++) begin
         send_query(1'($urandom), random_coord(center_x_q), random_coord(center_y_q),
                    random_coord(center_z_q), random_side());
      end
      finish_stimulus();
   endtask

   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = REG_SHAPE_KIND;
      csr_wdata      = 32'h0;
      req_chan.valid = 1'b0;
      req_chan.operation = OP_POINT;
      req_chan.query_x   = 32'h0;
      req_chan.query_y   = 32'h0;
      req_chan.query_z   = 32'h0;
      req_chan.cube_side = 31'h0;
      rsp_chan.ready     = 1'b0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      test_reset_shape();
      test_directed_shapes();

      // Sender idles lightly, receiver heavily; then the reverse; then none.
      send_idle_pct = 9;
      recv_idle_pct = 71;
      test_random_queries(13, 30);
      send_idle_pct = 71;
      recv_idle_pct = 9;
      test_random_queries(13, 30);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_queries(13, 30);
      test_backpressure();

      wait_idle();
      if (!failed) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("tb: FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
src/spcq_pkg.sv
src/spcq_req_if.sv
src/spcq_rsp_if.sv
src/spcq_mul.sv
src/spcq_clamp.sv
src/spcq_eval.sv
src/shape_point_cube_query_core.sv
src/spcq_check.sv
sim/tb.sv
